[hdl/pofp_pkg.sv]
// Shared types, constants and tables for the prism facet point test.
package pofp_pkg;

  localparam int FRAC_BITS = 16;

  // Tolerance in Q.FRAC_BITS: round(0.001 * 2^FRAC_BITS)
  localparam int EPS_Q = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int EPS_W = (EPS_Q < 2) ? 1 : $clog2(EPS_Q + 1);
  localparam int EPS_SQ_W = 2 * EPS_W + 2;
  localparam longint EPS_SQ = longint'(EPS_Q) * longint'(EPS_Q);

  localparam int CFG_W   = 27;
  localparam int COORD_W = 28;
  localparam int ARM_W   = 29;
  localparam int MAG_W   = 28;
  localparam int LEAD_W  = 5;
  localparam int NRM_W   = 16;
  localparam int NORM_TOP = 14;
  localparam int PROD_W  = 32;
  localparam int CRS_W   = 33;
  localparam int DOT_W   = 34;
  localparam int SQ_W    = 64;
  localparam int RAD_W   = 66;
  localparam int ROOT_W  = 32;
  localparam int CX_W    = 36;
  localparam int CZ_W    = 34;
  localparam int ANG_W   = FRAC_BITS + 2;
  localparam int SUM_W   = FRAC_BITS + 4;
  localparam int DIFF_W  = FRAC_BITS + 5;

  localparam int ISQ_STEPS    = ROOT_W;
  localparam int CORDIC_STEPS = 31;
  localparam int FRONT_LAT    = 3;
  localparam int ANG_PRE_LAT  = 4;
  localparam int ANG_LAT      = ANG_PRE_LAT + ISQ_STEPS + CORDIC_STEPS + 2;
  localparam int TOT_LAT      = FRONT_LAT + ANG_LAT + 2;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam int     RND_SH      = 30 - FRAC_BITS;
  localparam longint RND_HALF    = 64'sd1 << (RND_SH - 1);
  localparam longint TWO_PI_Q    = (TWO_PI_Q30 + RND_HALF) >>> RND_SH;

  typedef enum logic [2:0] {
    FACET_TOP    = 3'd0,
    FACET_BOTTOM = 3'd1,
    FACET_POS_X  = 3'd2,
    FACET_NEG_X  = 3'd3,
    FACET_BACK   = 3'd4,
    FACET_FRONT  = 3'd5
  } facet_e;

  typedef enum logic [2:0] {
    REG_NEAR_HALF_WIDTH  = 3'd0,
    REG_FAR_HALF_WIDTH   = 3'd1,
    REG_NEAR_HALF_HEIGHT = 3'd2,
    REG_FAR_HALF_HEIGHT  = 3'd3,
    REG_HALF_LENGTH      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]                facet;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic on_facet;
    logic at_vertex;
    logic bad_facet;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] near_w;
    logic [CFG_W-1:0] far_w;
    logic [CFG_W-1:0] near_h;
    logic [CFG_W-1:0] far_h;
    logic [CFG_W-1:0] half_len;
  } cfg_t;

  typedef logic signed [NRM_W-1:0] nrm_t;

  // vertex code: bit0 x minus, bit1 y minus, bit2 far end; packed {v3,v2,v1,v0}
  function automatic logic [2:0] face_vtx(logic [2:0] facet, logic [1:0] k);
    logic [11:0] row;
    case (facet)
      FACET_TOP:    row = {3'd5, 3'd4, 3'd0, 3'd1};
      FACET_BOTTOM: row = {3'd7, 3'd6, 3'd2, 3'd3};
      FACET_POS_X:  row = {3'd2, 3'd6, 3'd4, 3'd0};
      FACET_NEG_X:  row = {3'd5, 3'd7, 3'd3, 3'd1};
      FACET_BACK:   row = {3'd1, 3'd0, 3'd2, 3'd3};
      FACET_FRONT:  row = {3'd5, 3'd4, 3'd6, 3'd7};
      default:      row = '0;
    endcase
    return row[k*3 +: 3];
  endfunction

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/point_on_prism_facet_test.sv]
// Top level of the prism facet point test.
// Tests whether a Q12.16 point lies on one face of a trapezoidal prism set by
// five half-size registers, by a vertex-distance check and an angle sum.
// Input: a transaction is taken at each clock edge with start high and busy
// low. busy is tied low: one transaction can enter every cycle.
// Output: each result is shown for one cycle with out_strobe high; order is
// kept. The depth is set by the 32-stage square root and the 31-stage
// CORDIC in each of the four angle lanes. Throughput is one result per cycle.
// Facet indexes 6 and 7 give bad_facet with on_facet low.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 near
// half-width, 1 far half-width, 2 near half-height, 3 far half-height,
// 4 half-length); other indexes are ignored. Write only while no
// transaction is in flight.
// Reset (synchronous, rst_n low) clears the registers and drops all
// transactions in flight. The receiver cannot stall: results are not held.
module point_on_prism_facet_test (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  pofp_pkg::in_item_t           in_data,
  output logic                         out_strobe,
  output pofp_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [pofp_pkg::CFG_W-1:0]   cfg_wdata
);
  import pofp_pkg::*;

  localparam int VLD_LEN = FRONT_LAT + ANG_LAT;

  cfg_t              cfg_r, cfg_nxt;
  logic              accept;
  nrm_t              arm [4][3];
  logic              front_hit, front_bad;
  logic [ANG_W-1:0]  angle [4];
  logic [VLD_LEN-1:0] vld_r;
  logic [ANG_LAT-1:0] hit_line_r, bad_line_r;
  logic [SUM_W-1:0]  sum_nxt, sum_r;
  logic              sum_vld_r, sum_hit_r, sum_bad_r;
  logic signed [DIFF_W-1:0] diff;
  logic              close;
  out_item_t         out_nxt, out_r;
  logic              out_vld_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_NEAR_HALF_WIDTH:  cfg_nxt.near_w   = cfg_wdata;
        REG_FAR_HALF_WIDTH:   cfg_nxt.far_w    = cfg_wdata;
        REG_NEAR_HALF_HEIGHT: cfg_nxt.near_h   = cfg_wdata;
        REG_FAR_HALF_HEIGHT:  cfg_nxt.far_h    = cfg_wdata;
        REG_HALF_LENGTH:      cfg_nxt.half_len = cfg_wdata;
        default: ;
      endcase
    end
  end

  pofp_front u_front (
    .clk     (clk),
    .in_item (in_data),
    .cfg     (cfg_r),
    .arm_o   (arm),
    .hit_o   (front_hit),
    .bad_o   (front_bad)
  );

  // angle k spans arm k and arm k+1 (wrapping)
  for (genvar k = 0; k < 4; k++) begin : g_lane
    pofp_angle u_angle (
      .clk     (clk),
      .a_i     (arm[k]),
      .b_i     (arm[(k + 1) % 4]),
      .angle_o (angle[k])
    );
  end

  assign sum_nxt = SUM_W'(angle[0]) + SUM_W'(angle[1]) + SUM_W'(angle[2]) + SUM_W'(angle[3]);

  always_comb begin
    diff  = signed'({1'b0, sum_r}) - DIFF_W'(TWO_PI_Q);
    close = (diff < DIFF_W'(EPS_Q)) && (diff > -DIFF_W'(EPS_Q));
    out_nxt = '0;
    if (sum_bad_r) begin
      out_nxt.bad_facet = 1'b1;
    end else if (sum_hit_r) begin
      out_nxt.on_facet  = 1'b1;
      out_nxt.at_vertex = 1'b1;
    end else begin
      out_nxt.on_facet  = close;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '0;
      vld_r     <= '0;
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      vld_r     <= {vld_r[VLD_LEN-2:0], accept};
      sum_vld_r <= vld_r[VLD_LEN-1];
      out_vld_r <= sum_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_line_r <= {hit_line_r[ANG_LAT-2:0], front_hit};
    bad_line_r <= {bad_line_r[ANG_LAT-2:0], front_bad};
    sum_r      <= sum_nxt;
    sum_hit_r  <= hit_line_r[ANG_LAT-1];
    sum_bad_r  <= bad_line_r[ANG_LAT-1];
    out_r      <= out_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

[hdl/pofp_front.sv]
// Arm vectors, vertex-hit test and arm normalization (three stages).
module pofp_front (
  input  logic              clk,
  input  pofp_pkg::in_item_t in_item,
  input  pofp_pkg::cfg_t    cfg,
  output pofp_pkg::nrm_t    arm_o [4][3],
  output logic              hit_o,
  output logic              bad_o
);
  import pofp_pkg::*;

  logic signed [ARM_W-1:0] arm1_nxt [4][3];
  logic signed [ARM_W-1:0] arm1_r   [4][3];
  logic                    bad1_r;

  logic [MAG_W-1:0] mag2_nxt [4][3];
  logic [MAG_W-1:0] mag2_r   [4][3];
  logic             neg2_nxt [4][3];
  logic             neg2_r   [4][3];
  logic [3:0]       small2_nxt, small2_r;
  logic [MAG_W-1:0] max2_nxt [4];
  logic [MAG_W-1:0] max2_r   [4];
  logic             bad2_r;

  nrm_t arm3_nxt [4][3];
  nrm_t arm3_r   [4][3];
  logic hit3_nxt, hit3_r, bad3_r;

  // stage 1: point to vertex vectors
  always_comb begin
    logic [2:0] code;
    logic signed [ARM_W-1:0] vx, vy, vz;
    for (int k = 0; k < 4; k++) begin
      code = face_vtx(in_item.facet, 2'(k));
      vx = {2'b00, (code[2] ? cfg.far_w : cfg.near_w)};
      vy = {2'b00, (code[2] ? cfg.far_h : cfg.near_h)};
      vz = {2'b00, cfg.half_len};
      if (code[0]) vx = -vx;
      if (code[1]) vy = -vy;
      if (!code[2]) vz = -vz;
      arm1_nxt[k][0] = vx - ARM_W'(in_item.point_x);
      arm1_nxt[k][1] = vy - ARM_W'(in_item.point_y);
      arm1_nxt[k][2] = vz - ARM_W'(in_item.point_z);
    end
  end

  // stage 2: magnitudes, largest component, near-zero flags
  always_comb begin
    logic all_small;
    for (int k = 0; k < 4; k++) begin
      max2_nxt[k] = '0;
      all_small = 1'b1;
      for (int j = 0; j < 3; j++) begin
        neg2_nxt[k][j] = arm1_r[k][j][ARM_W-1];
        mag2_nxt[k][j] = neg2_nxt[k][j] ? MAG_W'(-arm1_r[k][j]) : MAG_W'(arm1_r[k][j]);
        if (mag2_nxt[k][j] > max2_nxt[k]) max2_nxt[k] = mag2_nxt[k][j];
        if (!(mag2_nxt[k][j] < MAG_W'(EPS_Q))) all_small = 1'b0;
      end
      small2_nxt[k] = all_small;
    end
  end

  // stage 3: exact |arm|^2 < eps^2, and scale so the largest part is in [2^14, 2^15)
  always_comb begin
    logic [LEAD_W-1:0]   lead;
    logic [MAG_W-1:0]    sm;
    logic [EPS_SQ_W-1:0] acc;
    logic [EPS_W-1:0]    lo;
    hit3_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      lead = '0;
      for (int b = 0; b < MAG_W; b++) begin
        if (max2_r[k][b]) lead = LEAD_W'(b);
      end
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        lo  = mag2_r[k][j][EPS_W-1:0];
        acc = acc + EPS_SQ_W'(lo) * EPS_SQ_W'(lo);
        if (lead > LEAD_W'(NORM_TOP))
          sm = mag2_r[k][j] >> (lead - LEAD_W'(NORM_TOP));
        else
          sm = mag2_r[k][j] << (LEAD_W'(NORM_TOP) - lead);
        arm3_nxt[k][j] = neg2_r[k][j] ? -nrm_t'({1'b0, sm[NRM_W-2:0]})
                                      :  nrm_t'({1'b0, sm[NRM_W-2:0]});
      end
      if (small2_r[k] && (acc < EPS_SQ_W'(EPS_SQ))) hit3_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    arm1_r   <= arm1_nxt;
    bad1_r   <= (in_item.facet > FACET_FRONT);
    mag2_r   <= mag2_nxt;
    neg2_r   <= neg2_nxt;
    small2_r <= small2_nxt;
    max2_r   <= max2_nxt;
    bad2_r   <= bad1_r;
    arm3_r   <= arm3_nxt;
    hit3_r   <= hit3_nxt;
    bad3_r   <= bad2_r;
  end

  assign arm_o = arm3_r;
  assign hit_o = hit3_r;
  assign bad_o = bad3_r;

endmodule

[hdl/pofp_isqrt.sv]
// Pipelined floor square root, one result bit per stage, dot product carried along.
module pofp_isqrt (
  input  logic                               clk,
  input  logic [pofp_pkg::SQ_W-1:0]          rad_i,
  input  logic signed [pofp_pkg::DOT_W-1:0]  dot_i,
  output logic [pofp_pkg::ROOT_W-1:0]        root_o,
  output logic signed [pofp_pkg::DOT_W-1:0]  dot_o
);
  import pofp_pkg::*;

  logic [RAD_W-1:0]        rem_nxt [ISQ_STEPS];
  logic [RAD_W-1:0]        rem_r   [ISQ_STEPS];
  logic [ROOT_W-1:0]       q_nxt   [ISQ_STEPS];
  logic [ROOT_W-1:0]       q_r     [ISQ_STEPS];
  logic signed [DOT_W-1:0] dot_r   [ISQ_STEPS];

  for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_step
    localparam int B = ROOT_W - 1 - g;
    logic [RAD_W-1:0]        rem_in;
    logic [ROOT_W-1:0]       q_in;
    logic signed [DOT_W-1:0] dot_in;
    logic [RAD_W-1:0]        trial;

    if (g == 0) begin : g_first
      assign rem_in = RAD_W'(rad_i);
      assign q_in   = '0;
      assign dot_in = dot_i;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign q_in   = q_r[g-1];
      assign dot_in = dot_r[g-1];
    end

    // (q + 2^B)^2 <= n  <=>  n - q^2 >= q*2^(B+1) + 2^(2B)
    always_comb begin
      trial = (RAD_W'(q_in) << (B + 1)) | (RAD_W'(1) << (2 * B));
      if (rem_in >= trial) begin
        rem_nxt[g] = rem_in - trial;
        q_nxt[g]   = q_in | (ROOT_W'(1) << B);
      end else begin
        rem_nxt[g] = rem_in;
        q_nxt[g]   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= rem_nxt[g];
      q_r[g]   <= q_nxt[g];
      dot_r[g] <= dot_in;
    end
  end

  assign root_o = q_r[ISQ_STEPS-1];
  assign dot_o  = dot_r[ISQ_STEPS-1];

endmodule

[hdl/pofp_cordic.sv]
// Pipelined vectoring CORDIC atan2 for y >= 0, clamped to [0, pi], rounded to Q.FRAC_BITS.
module pofp_cordic (
  input  logic                              clk,
  input  logic [pofp_pkg::ROOT_W-1:0]       y_i,
  input  logic signed [pofp_pkg::DOT_W-1:0] x_i,
  output logic [pofp_pkg::ANG_W-1:0]        angle_o
);
  import pofp_pkg::*;

  logic signed [CX_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] z_r [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] x_nxt [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] y_nxt [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] z_nxt [CORDIC_STEPS+1];
  logic [ANG_W-1:0]       angle_nxt, angle_r;

  // negative x: rotate by -pi/2 first
  always_comb begin
    if (x_i < 0) begin
      x_nxt[0] = CX_W'(signed'({1'b0, y_i}));
      y_nxt[0] = -CX_W'(x_i);
      z_nxt[0] = CZ_W'(HALF_PI_Q30);
    end else begin
      x_nxt[0] = CX_W'(x_i);
      y_nxt[0] = CX_W'(signed'({1'b0, y_i}));
      z_nxt[0] = '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [CX_W-1:0] dx, dy;
    logic signed [CZ_W-1:0] az;
    always_comb begin
      dx = y_r[g] >>> g;
      dy = x_r[g] >>> g;
      az = CZ_W'(signed'({1'b0, atan_q30(g)}));
      if (y_r[g] > 0) begin
        x_nxt[g+1] = x_r[g] + dx;
        y_nxt[g+1] = y_r[g] - dy;
        z_nxt[g+1] = z_r[g] + az;
      end else if (y_r[g] < 0) begin
        x_nxt[g+1] = x_r[g] - dx;
        y_nxt[g+1] = y_r[g] + dy;
        z_nxt[g+1] = z_r[g] - az;
      end else begin
        x_nxt[g+1] = x_r[g];
        y_nxt[g+1] = y_r[g];
        z_nxt[g+1] = z_r[g];
      end
    end
  end

  always_comb begin
    logic signed [CZ_W-1:0] zc;
    zc = z_r[CORDIC_STEPS];
    if (zc < 0) zc = '0;
    else if (CZ_W'(PI_Q30) < zc) zc = CZ_W'(PI_Q30);
    angle_nxt = ANG_W'((zc + CZ_W'(RND_HALF)) >>> RND_SH);
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    angle_r <= angle_nxt;
  end

  assign angle_o = angle_r;

endmodule

[hdl/pofp_angle.sv]
// Angle between two normalized arms: products, |a x b|, sqrt, then CORDIC atan2.
module pofp_angle (
  input  logic                       clk,
  input  pofp_pkg::nrm_t             a_i [3],
  input  pofp_pkg::nrm_t             b_i [3],
  output logic [pofp_pkg::ANG_W-1:0] angle_o
);
  import pofp_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [PROD_W-1:0] prod_r   [9];
  logic signed [CRS_W-1:0]  crs_nxt  [3];
  logic signed [CRS_W-1:0]  crs_r    [3];
  logic signed [DOT_W-1:0]  dot2_nxt, dot2_r, dot3_r, dot4_r;
  logic [SQ_W-1:0]          sq_nxt   [3];
  logic [SQ_W-1:0]          sq_r     [3];
  logic [SQ_W-1:0]          rad_nxt, rad_r;
  logic [ROOT_W-1:0]        root;
  logic signed [DOT_W-1:0]  dot_dly;

  always_comb begin
    prod_nxt[0] = PROD_W'(a_i[1] * b_i[2]);
    prod_nxt[1] = PROD_W'(a_i[2] * b_i[1]);
    prod_nxt[2] = PROD_W'(a_i[2] * b_i[0]);
    prod_nxt[3] = PROD_W'(a_i[0] * b_i[2]);
    prod_nxt[4] = PROD_W'(a_i[0] * b_i[1]);
    prod_nxt[5] = PROD_W'(a_i[1] * b_i[0]);
    prod_nxt[6] = PROD_W'(a_i[0] * b_i[0]);
    prod_nxt[7] = PROD_W'(a_i[1] * b_i[1]);
    prod_nxt[8] = PROD_W'(a_i[2] * b_i[2]);
  end

  always_comb begin
    for (int j = 0; j < 3; j++)
      crs_nxt[j] = CRS_W'(prod_r[2*j]) - CRS_W'(prod_r[2*j+1]);
    dot2_nxt = DOT_W'(prod_r[6]) + DOT_W'(prod_r[7]) + DOT_W'(prod_r[8]);
  end

  always_comb begin
    logic [ROOT_W-1:0] cm;
    for (int j = 0; j < 3; j++) begin
      cm = (crs_r[j] < 0) ? ROOT_W'(-crs_r[j]) : ROOT_W'(crs_r[j]);
      sq_nxt[j] = SQ_W'(cm) * SQ_W'(cm);
    end
  end

  assign rad_nxt = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    crs_r  <= crs_nxt;
    dot2_r <= dot2_nxt;
    sq_r   <= sq_nxt;
    dot3_r <= dot2_r;
    rad_r  <= rad_nxt;
    dot4_r <= dot3_r;
  end

  pofp_isqrt u_isqrt (
    .clk    (clk),
    .rad_i  (rad_r),
    .dot_i  (dot4_r),
    .root_o (root),
    .dot_o  (dot_dly)
  );

  pofp_cordic u_cordic (
    .clk     (clk),
    .y_i     (root),
    .x_i     (dot_dly),
    .angle_o (angle_o)
  );

endmodule

[hdl/pofp_checker.sv]
// Port-level checks for the prism facet point test, bound to the top level.
module pofp_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input pofp_pkg::out_item_t out_data
);
  import pofp_pkg::*;

  // reset drops everything in flight
  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // every result belongs to a transaction taken a fixed latency earlier
  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, TOT_LAT))
    else $error("result without a matching transaction");

  a_bad_not_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.bad_facet |-> !out_data.on_facet && !out_data.at_vertex)
    else $error("bad facet with on_facet or at_vertex set");

  a_vertex_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.at_vertex |-> out_data.on_facet)
    else $error("vertex hit without on_facet");

endmodule

bind point_on_prism_facet_test pofp_port_props u_pofp_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
